// File: rtl/core/imhdk_pkg.sv
// Shared types and constants for the indexed max-heap block.
package imhdk_pkg;

    // Fixed field widths of the stream payload
    localparam int ID_W        = 10;
    localparam int SLOT_W      = 10;
    localparam int CNT_W       = 11;
    localparam int WVAL_W      = 32;
    localparam int S_TDATA_W   = 88;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 48;
    localparam int M_TUSER_W   = 2;
    localparam int M_PAD_W     = M_TDATA_W - ID_W - WVAL_W;

    // Entry count after reset
    localparam logic [CNT_W-1:0] ENTRY_COUNT_RESET = 11'd1024;

    // Operation codes carried in the slave-side tuser
    typedef enum logic [1:0] {
        OP_LOAD     = 2'd0,
        OP_BUILD    = 2'd1,
        OP_DECREASE = 2'd2,
        OP_READ     = 2'd3
    } op_t;

    // Result status codes carried in the master-side tuser
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_SAT   = 2'd2
    } status_t;

    // One command as taken from the input stream
    typedef struct packed {
        op_t                op;
        logic [SLOT_W-1:0]  slot;
        logic [ID_W-1:0]    item_id;
        logic [WVAL_W-1:0]  weight_value;
        logic [WVAL_W-1:0]  decrease_amount;
    } cmd_t;

    // One result for the output stream
    typedef struct packed {
        logic [ID_W-1:0]    top_id;
        logic [WVAL_W-1:0]  top_weight;
        status_t            status;
    } res_t;

endpackage

// File: rtl/core/imhdk_ctrl.sv
// Heap sequencer: holds the heap store and the id-to-slot map in two
// synchronous memories and runs load, build, decrease/sift-down and
// read-top as read-modify-write sequences over them.
module imhdk_ctrl #(
    parameter int CAPACITY    = 1024,
    parameter int WEIGHT_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [imhdk_pkg::CNT_W-1:0]   entry_count,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  imhdk_pkg::cmd_t               cmd,
    output logic                          res_valid,
    input  logic                          res_ready,
    output imhdk_pkg::res_t               res
);

    localparam int AW = $clog2(CAPACITY);
    localparam int NW = $clog2(CAPACITY + 1);
    localparam int CW = AW + 2;
    localparam int WB = WEIGHT_BITS;
    localparam int HW = imhdk_pkg::ID_W + WB;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD_WR,
        S_DEC_POS,
        S_DEC_WT,
        S_BLD_NEXT,
        S_BLD_LOAD,
        S_SIFT_RD,
        S_SIFT_CMP,
        S_MAP_RD,
        S_MAP_WR,
        S_TOP_RD,
        S_TOP_WAIT,
        S_DONE
    } state_t;

    // Memories and their registered read data
    logic [HW-1:0]               heap_mem [CAPACITY];
    logic [AW-1:0]               map_mem  [CAPACITY];
    logic [HW-1:0]               heap_rd_a;
    logic [HW-1:0]               heap_rd_b;
    logic [AW-1:0]               map_rd;

    // Memory port controls
    logic                        heap_we;
    logic [AW-1:0]               heap_wa;
    logic [HW-1:0]               heap_wd;
    logic                        heap_re;
    logic [AW-1:0]               heap_ra_a;
    logic [AW-1:0]               heap_ra_b;
    logic                        map_re;
    logic [AW-1:0]               map_ra;
    logic                        map_we;
    logic [AW-1:0]               map_wa;
    logic [AW-1:0]               map_wd;

    // Sequencer registers
    state_t                      state_reg, state_next;
    imhdk_pkg::cmd_t             cmd_reg, cmd_next;
    logic [AW-1:0]               pos_reg, pos_next;
    logic [WB-1:0]               mov_w_reg, mov_w_next;
    logic [imhdk_pkg::ID_W-1:0]  mov_id_reg, mov_id_next;
    logic                        moved_reg, moved_next;
    logic                        track_reg, track_next;
    logic [NW-1:0]               cnt_reg, cnt_next;
    imhdk_pkg::status_t          status_reg, status_next;
    imhdk_pkg::res_t             res_reg, res_next;

    // Datapath helpers
    logic [NW-1:0]               n_active;
    logic [CW-1:0]               left_idx;
    logic [CW-1:0]               right_idx;
    logic                        left_in;
    logic                        right_in;
    logic [WB-1:0]               wa;
    logic [WB-1:0]               wb;
    logic [imhdk_pkg::ID_W-1:0]  ida;
    logic [imhdk_pkg::ID_W-1:0]  idb;
    logic                        pick_right;
    logic [WB-1:0]               best_w;
    logic [imhdk_pkg::ID_W-1:0]  best_id;
    logic [AW-1:0]               best_pos;
    logic                        dec_sat;
    logic [WB-1:0]               dec_w;
    logic                        sift_finish;

    // Entry count clamped to the range 1 .. CAPACITY
    always_comb
    begin
        if (entry_count == '0)
        begin
            n_active = NW'(1);
        end
        else if (32'(entry_count) > 32'(CAPACITY))
        begin
            n_active = NW'(CAPACITY);
        end
        else
        begin
            n_active = NW'(entry_count);
        end
    end

    // Children of the current slot and the heavier of the two
    assign left_idx   = {1'b0, pos_reg, 1'b1};
    assign right_idx  = left_idx + CW'(1);
    assign left_in    = 32'(left_idx) < 32'(n_active);
    assign right_in   = 32'(right_idx) < 32'(n_active);
    assign wa         = heap_rd_a[WB-1:0];
    assign wb         = heap_rd_b[WB-1:0];
    assign ida        = heap_rd_a[HW-1:WB];
    assign idb        = heap_rd_b[HW-1:WB];
    assign pick_right = right_in && (wb > wa);
    assign best_w     = pick_right ? wb : wa;
    assign best_id    = pick_right ? idb : ida;
    assign best_pos   = pick_right ? right_idx[AW-1:0] : left_idx[AW-1:0];

    // Saturating decrease of the weight just read
    assign dec_sat = 64'(cmd_reg.decrease_amount) > 64'(wa);
    assign dec_w   = dec_sat ? '0 : (wa - WB'(cmd_reg.decrease_amount));

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    // Next-state and memory port logic
    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        pos_next    = pos_reg;
        mov_w_next  = mov_w_reg;
        mov_id_next = mov_id_reg;
        moved_next  = moved_reg;
        track_next  = track_reg;
        cnt_next    = cnt_reg;
        status_next = status_reg;
        res_next    = res_reg;
        heap_we     = 1'b0;
        heap_wa     = '0;
        heap_wd     = '0;
        heap_re     = 1'b0;
        heap_ra_a   = '0;
        heap_ra_b   = '0;
        map_re      = 1'b0;
        map_ra      = '0;
        map_we      = 1'b0;
        map_wa      = '0;
        map_wd      = '0;
        sift_finish = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next    = cmd;
                    status_next = imhdk_pkg::ST_OK;
                    moved_next  = 1'b0;
                    map_re      = 1'b1;
                    map_ra      = AW'(cmd.item_id);
                    unique case (cmd.op)
                        imhdk_pkg::OP_LOAD:
                        begin
                            state_next = S_LOAD_WR;
                        end
                        imhdk_pkg::OP_BUILD:
                        begin
                            track_next = 1'b0;
                            cnt_next   = n_active >> 1;
                            state_next = S_BLD_NEXT;
                        end
                        imhdk_pkg::OP_DECREASE:
                        begin
                            track_next = 1'b1;
                            state_next = S_DEC_POS;
                        end
                        imhdk_pkg::OP_READ:
                        begin
                            state_next = S_TOP_RD;
                        end
                    endcase
                end
            end

            // Store one entry and its map slot
            S_LOAD_WR:
            begin
                if ((32'(cmd_reg.slot) < 32'(n_active)) &&
                    (32'(cmd_reg.item_id) < 32'(CAPACITY)))
                begin
                    heap_we = 1'b1;
                    heap_wa = AW'(cmd_reg.slot);
                    heap_wd = {cmd_reg.item_id, WB'(cmd_reg.weight_value)};
                    map_we  = 1'b1;
                    map_wa  = AW'(cmd_reg.item_id);
                    map_wd  = AW'(cmd_reg.slot);
                end
                else
                begin
                    status_next = imhdk_pkg::ST_RANGE;
                end
                state_next = S_TOP_RD;
            end

            // Map lookup is back; check it and fetch the entry
            S_DEC_POS:
            begin
                if ((32'(cmd_reg.item_id) >= 32'(CAPACITY)) ||
                    (32'(map_rd) >= 32'(n_active)))
                begin
                    status_next = imhdk_pkg::ST_RANGE;
                    state_next  = S_TOP_RD;
                end
                else
                begin
                    heap_re    = 1'b1;
                    heap_ra_a  = map_rd;
                    pos_next   = map_rd;
                    state_next = S_DEC_WT;
                end
            end

            S_DEC_WT:
            begin
                mov_w_next  = dec_w;
                mov_id_next = ida;
                if (dec_sat)
                begin
                    status_next = imhdk_pkg::ST_SAT;
                end
                state_next = S_SIFT_RD;
            end

            // Bottom-up build: next internal slot, or on to the map rewrite
            S_BLD_NEXT:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_MAP_RD;
                end
                else
                begin
                    cnt_next   = cnt_reg - NW'(1);
                    pos_next   = AW'(cnt_reg - NW'(1));
                    heap_re    = 1'b1;
                    heap_ra_a  = AW'(cnt_reg - NW'(1));
                    moved_next = 1'b0;
                    state_next = S_BLD_LOAD;
                end
            end

            S_BLD_LOAD:
            begin
                mov_w_next  = wa;
                mov_id_next = ida;
                state_next  = S_SIFT_RD;
            end

            // Fetch both children, or settle the entry at a leaf
            S_SIFT_RD:
            begin
                if (!left_in)
                begin
                    sift_finish = 1'b1;
                end
                else
                begin
                    heap_re    = 1'b1;
                    heap_ra_a  = left_idx[AW-1:0];
                    heap_ra_b  = right_in ? right_idx[AW-1:0] : left_idx[AW-1:0];
                    state_next = S_SIFT_CMP;
                end
            end

            // Move the heavier child up, or settle the entry here
            S_SIFT_CMP:
            begin
                if (best_w > mov_w_reg)
                begin
                    heap_we = 1'b1;
                    heap_wa = pos_reg;
                    heap_wd = {best_id, best_w};
                    if (track_reg && (32'(best_id) < 32'(CAPACITY)))
                    begin
                        map_we = 1'b1;
                        map_wa = AW'(best_id);
                        map_wd = pos_reg;
                    end
                    pos_next   = best_pos;
                    moved_next = 1'b1;
                    state_next = S_SIFT_RD;
                end
                else
                begin
                    sift_finish = 1'b1;
                end
            end

            // Map rewrite after a build, lowest slot first
            S_MAP_RD:
            begin
                heap_re    = 1'b1;
                heap_ra_a  = cnt_reg[AW-1:0];
                state_next = S_MAP_WR;
            end

            S_MAP_WR:
            begin
                if (32'(ida) < 32'(CAPACITY))
                begin
                    map_we = 1'b1;
                    map_wa = AW'(ida);
                    map_wd = cnt_reg[AW-1:0];
                end
                if (NW'(cnt_reg + NW'(1)) == n_active)
                begin
                    state_next = S_TOP_RD;
                end
                else
                begin
                    cnt_next   = cnt_reg + NW'(1);
                    state_next = S_MAP_RD;
                end
            end

            S_TOP_RD:
            begin
                heap_re    = 1'b1;
                heap_ra_a  = '0;
                state_next = S_TOP_WAIT;
            end

            S_TOP_WAIT:
            begin
                res_next.top_id     = ida;
                res_next.top_weight = imhdk_pkg::WVAL_W'(wa);
                res_next.status     = status_reg;
                state_next          = S_DONE;
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Write the moving entry into its final slot
        if (sift_finish)
        begin
            heap_we = 1'b1;
            heap_wa = pos_reg;
            heap_wd = {mov_id_reg, mov_w_reg};
            if (track_reg && moved_reg && (32'(mov_id_reg) < 32'(CAPACITY)))
            begin
                map_we = 1'b1;
                map_wa = AW'(mov_id_reg);
                map_wd = pos_reg;
            end
            state_next = track_reg ? S_TOP_RD : S_BLD_NEXT;
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cmd_reg    <= '0;
            pos_reg    <= '0;
            mov_w_reg  <= '0;
            mov_id_reg <= '0;
            moved_reg  <= 1'b0;
            track_reg  <= 1'b0;
            cnt_reg    <= '0;
            status_reg <= imhdk_pkg::ST_OK;
            res_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cmd_reg    <= cmd_next;
            pos_reg    <= pos_next;
            mov_w_reg  <= mov_w_next;
            mov_id_reg <= mov_id_next;
            moved_reg  <= moved_next;
            track_reg  <= track_next;
            cnt_reg    <= cnt_next;
            status_reg <= status_next;
            res_reg    <= res_next;
        end
    end

    // Heap store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (heap_we)
        begin
            heap_mem[heap_wa] <= heap_wd;
        end
        if (heap_re)
        begin
            heap_rd_a <= heap_mem[heap_ra_a];
            heap_rd_b <= heap_mem[heap_ra_b];
        end
    end

    // Id-to-slot map: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_wa] <= map_wd;
        end
        if (map_re)
        begin
            map_rd <= map_mem[map_ra];
        end
    end

endmodule

// File: rtl/core/indexed_max_heap_decrease_key_top.sv
// One item is in work at a time: a new input transaction is taken only after the result
// of the last one has gone to the output register. Every operation ends with a read of the
// top slot; a decrease of an id mapped outside the heap skips the sift with a range status,
// else the entry sinks up to 10 levels at 1024, one read-compare-write per heap level;
// a build sifts each internal slot down and then rewrites the map.
// Reset is asynchronous, active low; it sets the entry count to 1024; memories hold no reset.
module indexed_max_heap_decrease_key_top #(
    parameter int CAPACITY    = 1024,
    parameter int WEIGHT_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [imhdk_pkg::CNT_W-1:0]       cfg_wr_data,    // entry_count
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // slot[9:0], item_id[19:10], weight_value[51:20], decrease_amount[83:52]
    input  logic [imhdk_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  logic [imhdk_pkg::S_TUSER_W-1:0]   s_axis_tuser,   // operation[1:0]
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [imhdk_pkg::M_TDATA_W-1:0]   m_axis_tdata,   // top_id[9:0], top_weight[41:10]
    output logic [imhdk_pkg::M_TUSER_W-1:0]   m_axis_tuser    // status[1:0]
);

    logic [imhdk_pkg::CNT_W-1:0] entry_count_reg, entry_count_next;
    logic                        m_valid_reg, m_valid_next;
    imhdk_pkg::res_t             m_res_reg, m_res_next;
    imhdk_pkg::cmd_t             cmd;
    imhdk_pkg::res_t             res;
    logic                        res_valid;
    logic                        res_ready;

    // Unpack the input transaction
    always_comb
    begin
        cmd.op              = imhdk_pkg::op_t'(s_axis_tuser);
        cmd.slot            = s_axis_tdata[9:0];
        cmd.item_id         = s_axis_tdata[19:10];
        cmd.weight_value    = s_axis_tdata[51:20];
        cmd.decrease_amount = s_axis_tdata[83:52];
    end

    imhdk_ctrl #(
        .CAPACITY    (CAPACITY),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_count (entry_count_reg),
        .cmd_valid   (s_axis_tvalid),
        .cmd_ready   (s_axis_tready),
        .cmd         (cmd),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // The output register takes a result from the sequencer when it is empty or being drained
    assign res_ready = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        entry_count_next = cfg_wr_en ? cfg_wr_data : entry_count_reg;
        m_res_next       = m_res_reg;
        m_valid_next     = m_valid_reg;
        if (res_valid && res_ready)
        begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= imhdk_pkg::ENTRY_COUNT_RESET;
            m_valid_reg     <= 1'b0;
            m_res_reg       <= '0;
        end
        else
        begin
            entry_count_reg <= entry_count_next;
            m_valid_reg     <= m_valid_next;
            m_res_reg       <= m_res_next;
        end
    end

    // Pack the output transaction
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{imhdk_pkg::M_PAD_W{1'b0}}, m_res_reg.top_weight, m_res_reg.top_id};
    assign m_axis_tuser  = m_res_reg.status;

endmodule

// File: rtl/core/imhdk_checker.sv
// Port-level checks for the heap block.
module imhdk_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // Only one item is in work: input closes right after a transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item accepted while busy");

    // No result can appear in the cycle right after an item is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result faster than the minimum latency");

    // A new result is handed over only while the input side is closed.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result handed over while input was open");

endmodule

bind indexed_max_heap_decrease_key_top imhdk_checker u_imhdk_checker (.*);
